// ===== sv/gss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types and constants for the gamepad serial shift-out block.
// ----------------------------------------------------------------------------
package gss_pkg;

	// length of the serial frame: 12 buttons and 4 signature bits
	localparam int unsigned CHAIN_LEN = 16;
	localparam int unsigned BTN_W     = 12;

	// command codes of an input item
	typedef enum logic {
		CMD_LATCH = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	// button positions in the live word
	localparam int unsigned BTN_B     = 0;
	localparam int unsigned BTN_UP    = 4;
	localparam int unsigned BTN_DOWN  = 5;
	localparam int unsigned BTN_LEFT  = 6;
	localparam int unsigned BTN_RIGHT = 7;

	// control shared by every cell of the chain
	typedef struct packed {
		logic load;
		logic shift;
	} chain_ctrl_t;

endpackage

// ===== sv/gss_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_in_if / gss_out_if
// Valid/ready channels for pad commands and returned serial bits.
// ----------------------------------------------------------------------------
interface gss_in_if;
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic                         latch_level;
	logic [gss_pkg::BTN_W-1:0]    buttons;

	modport source (output valid, command, latch_level, buttons, input ready);
	modport sink   (input valid, command, latch_level, buttons, output ready);
endinterface

interface gss_out_if;
	logic valid;
	logic ready;
	logic serial_bit;

	modport source (output valid, serial_bit, input ready);
	modport sink   (input valid, serial_bit, output ready);
endinterface

// ===== sv/gss_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_cell
// One bit of the serial frame: parallel load or shift from its neighbor.
// ----------------------------------------------------------------------------
module gss_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gss_pkg::chain_ctrl_t ctrl,
	input  logic                 load_bit,
	input  logic                 shift_in,
	output logic                 q
);
	import gss_pkg::*;

	logic bit_q;

	// load has priority; load and shift never come together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctrl.load) begin
			bit_q <= load_bit;
		end else if (ctrl.shift) begin
			bit_q <= shift_in;
		end
	end

	assign q = bit_q;

endmodule

// ===== sv/gss_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_axis
// Opposing-direction hold rule for one dpad axis (up/down or left/right).
// ----------------------------------------------------------------------------
module gss_axis (
	input  logic clk,
	input  logic arst_n,
	input  logic capture,
	input  logic live_a,
	input  logic live_b,
	output logic a_nxt,
	output logic b_nxt
);
	import gss_pkg::*;

	logic a_q, b_q, hold_q;
	logic hold_nxt;

	// both held: swap once, then keep; otherwise follow live buttons
	always_comb begin
		if (!(live_a && live_b)) begin
			hold_nxt = 1'b0;
			a_nxt    = live_a;
			b_nxt    = live_b;
		end else if (!hold_q) begin
			hold_nxt = 1'b1;
			a_nxt    = b_q;
			b_nxt    = a_q;
		end else begin
			hold_nxt = 1'b1;
			a_nxt    = a_q;
			b_nxt    = b_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= 1'b0;
			b_q    <= 1'b0;
			hold_q <= 1'b0;
		end else if (capture) begin
			a_q    <= a_nxt;
			b_q    <= b_nxt;
			hold_q <= hold_nxt;
		end
	end

endmodule

// ===== sv/gamepad_serial_shift_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_serial_shift_out
// 12-button pad: latch captures buttons into a 16-cell chain, reads shift it.
// ----------------------------------------------------------------------------
//  channel   dir  payload                          per item
//  request   in   command, latch_level, buttons    latch write or read
//  response  out  serial_bit                       one per read
//
//  one item per cycle while the response is not stalled; a read's bit shows in the cycle after acceptance
//  the output register frees request.ready whenever it is empty or taken
//  a falling latch loads the chain; each unlatched read shifts it, filling 1s
//  reset clears latch, chain and dpad state at once
//  a stalled response holds the register and stops request
// ----------------------------------------------------------------------------
module gamepad_serial_shift_out (
	input  logic      clk,
	input  logic      arst_n,
	gss_in_if.sink    request,
	gss_out_if.source response
);
	import gss_pkg::*;

	logic                 acc;
	logic                 is_read;
	logic                 latch_q;
	logic                 fall;
	chain_ctrl_t          ctrl;
	logic [CHAIN_LEN-1:0] load_vec;
	logic [CHAIN_LEN-1:0] cell_q;
	logic                 up_n, down_n, left_n, right_n;
	logic                 out_valid_q;
	logic                 out_bit_q;
	logic                 rd_bit;

	// handshake
	assign request.ready = !out_valid_q || response.ready;
	assign acc           = request.valid && request.ready;
	assign is_read       = (cmd_t'(request.command) == CMD_READ);
	assign fall          = acc && !is_read && latch_q && !request.latch_level;

	// chain control
	assign ctrl.load  = fall;
	assign ctrl.shift = acc && is_read && !latch_q;

	// dpad hold units
	gss_axis u_vert (
		.clk     (clk),
		.arst_n  (arst_n),
		.capture (fall),
		.live_a  (request.buttons[BTN_UP]),
		.live_b  (request.buttons[BTN_DOWN]),
		.a_nxt   (up_n),
		.b_nxt   (down_n)
	);

	gss_axis u_horz (
		.clk     (clk),
		.arst_n  (arst_n),
		.capture (fall),
		.live_a  (request.buttons[BTN_LEFT]),
		.live_b  (request.buttons[BTN_RIGHT]),
		.a_nxt   (left_n),
		.b_nxt   (right_n)
	);

	// frame: buttons with filtered dpad, then zero signature
	assign load_vec = {{(CHAIN_LEN - BTN_W){1'b0}}, request.buttons[11:8],
		right_n, left_n, down_n, up_n, request.buttons[3:0]};

	// chain of cells, ones shift in at the far end
	for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
		logic nb;
		if (i == CHAIN_LEN - 1) begin : g_end
			assign nb = 1'b1;
		end else begin : g_mid
			assign nb = cell_q[i+1];
		end
		gss_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.load_bit (load_vec[i]),
			.shift_in (nb),
			.q        (cell_q[i])
		);
	end

	// latch level tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= 1'b0;
		end else if (acc && !is_read) begin
			latch_q <= request.latch_level;
		end
	end

	// live B while latched, head of chain otherwise
	assign rd_bit = latch_q ? request.buttons[BTN_B] : cell_q[0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (request.ready) begin
			out_valid_q <= acc && is_read;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_read) begin
			out_bit_q <= rd_bit;
		end
	end

	assign response.valid      = out_valid_q;
	assign response.serial_bit = out_bit_q;

endmodule

// ===== sv/gss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_checker
// Port-level checks on the gamepad serial shift-out block.
// ----------------------------------------------------------------------------
module gss_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic command,
	input logic out_valid,
	input logic out_ready,
	input logic serial_bit
);
	import gss_pkg::*;

	logic free;
	assign free = !out_valid || out_ready;

	// an accepted read yields an item on the next cycle
	a_read_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd_t'(command) == CMD_READ |=> out_valid)
		else $error("read item produced no response");

	// a latch write yields nothing once the register is free
	a_latch_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd_t'(command) == CMD_LATCH && free |=> !out_valid)
		else $error("latch write produced a response");

	// a stalled response holds its item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(serial_bit))
		else $error("stalled response changed");

	// the block takes items whenever its output register is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		free |-> in_ready)
		else $error("request stalled with free output");

endmodule

bind gamepad_serial_shift_out gss_checker u_gss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (request.valid),
	.in_ready   (request.ready),
	.command    (request.command),
	.out_valid  (response.valid),
	.out_ready  (response.ready),
	.serial_bit (response.serial_bit)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gamepad serial shift-out block.
// A fixed list of pad commands opens the run: reset reads, latched reads,
// both hold rules and one full frame out to the saturated ones. Random latch
// and read frames follow. An internal pad model predicts each returned bit;
// typed rows carry their own. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
	import gss_pkg::*;

	localparam int RAND_ITEMS  = 1000;
	localparam int QUIET_ITEMS = 150;
	localparam int DIR_COUNT   = 26;

	logic clk;
	logic arst_n;

	gss_in_if  req_if ();
	gss_out_if rsp_if ();

	gamepad_serial_shift_out dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (req_if),
		.response (rsp_if)
	);

	// one row of the opening command list; typed rows carry their own answer
	typedef struct packed {
		cmd_t             cmd;
		logic             lvl;
		logic [BTN_W-1:0] btns;
		logic             typed;
		logic             exp_bit;
	} pad_row_t;

	localparam pad_row_t DIR_ROWS [DIR_COUNT] = '{
		'{CMD_READ,  1'b0, 12'hFFF, 1'b1, 1'b0},  // out of reset: zero capture
		'{CMD_LATCH, 1'b0, 12'hFFF, 1'b0, 1'b0},  // same level: no effect
		'{CMD_READ,  1'b0, 12'h000, 1'b1, 1'b0},
		'{CMD_LATCH, 1'b1, 12'h000, 1'b0, 1'b0},  // rising latch
		'{CMD_READ,  1'b0, 12'h001, 1'b1, 1'b1},  // latched: live B
		'{CMD_READ,  1'b0, 12'hFFE, 1'b1, 1'b0},
		'{CMD_LATCH, 1'b0, 12'h030, 1'b0, 1'b0},  // up and down held: swap
		'{CMD_LATCH, 1'b1, 12'h030, 1'b0, 1'b0},
		'{CMD_LATCH, 1'b0, 12'hFFF, 1'b0, 1'b0},  // vertical kept, horizontal swap
		'{CMD_READ,  1'b0, 12'h000, 1'b0, 1'b0},
		'{CMD_READ,  1'b0, 12'hFFF, 1'b0, 1'b0},
		'{CMD_READ,  1'b0, 12'h000, 1'b0, 1'b0},
		'{CMD_READ,  1'b0, 12'hFFF, 1'b0, 1'b0},
		'{CMD_READ,  1'b0, 12'h000, 1'b0, 1'b0},
		'{CMD_READ,  1'b0, 12'hFFF, 1'b0, 1'b0},
		'{CMD_READ,  1'b0, 12'h000, 1'b0, 1'b0},
		'{CMD_READ,  1'b0, 12'hFFF, 1'b0, 1'b0},
		'{CMD_READ,  1'b0, 12'h000, 1'b0, 1'b0},
		'{CMD_READ,  1'b0, 12'hFFF, 1'b0, 1'b0},
		'{CMD_READ,  1'b0, 12'h000, 1'b0, 1'b0},
		'{CMD_READ,  1'b0, 12'hFFF, 1'b0, 1'b0},
		'{CMD_READ,  1'b0, 12'h000, 1'b1, 1'b0},  // signature bits
		'{CMD_READ,  1'b0, 12'hFFF, 1'b1, 1'b0},
		'{CMD_READ,  1'b0, 12'h000, 1'b1, 1'b0},
		'{CMD_READ,  1'b0, 12'hFFF, 1'b1, 1'b0},
		'{CMD_READ,  1'b0, 12'h000, 1'b1, 1'b1}   // past the frame: ones
	};

	// pad model state
	logic             pad_latched;
	logic [4:0]       pad_pos;
	logic [BTN_W-1:0] pad_snap;
	logic             pad_up, pad_dn, pad_lt, pad_rt;
	logic             vert_hold, horiz_hold;

	// bits the pad owes the host, oldest first; typed rows push their answer
	logic pending_serial_bits [$];
	logic typed_answers [$];
	bit   typed_flags [$];

	int   bit_errors;
	int   items_sent;
	int   reads_seen;
	int   latches_seen;
	int   frames_sent;
	bit   quiet_phase;
	logic req_fire;

	// clock and reset
	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// pad behavior: latch edges capture, reads walk the frame
	task automatic pad_shift_predict(input cmd_t cmd, input logic lvl,
			input logic [BTN_W-1:0] btns, output logic produces, output logic bit_out);
		produces = 1'b0;
		bit_out  = 1'b0;
		if (cmd == CMD_READ) begin
			produces = 1'b1;
			if (pad_latched) begin
				bit_out = btns[BTN_B];
			end else if (pad_pos >= CHAIN_LEN) begin
				pad_pos = 5'(CHAIN_LEN);
				bit_out = 1'b1;
			end else begin
				case (pad_pos)
					BTN_UP:    bit_out = pad_up;
					BTN_DOWN:  bit_out = pad_dn;
					BTN_LEFT:  bit_out = pad_lt;
					BTN_RIGHT: bit_out = pad_rt;
					default:   bit_out = (pad_pos < BTN_W) ? pad_snap[pad_pos] : 1'b0;
				endcase
				pad_pos = pad_pos + 5'd1;
			end
		end else if (pad_latched != lvl) begin
			pad_latched = lvl;
			pad_pos     = '0;
			if (!lvl) begin
				pad_snap = btns;
				// opposing directions held: swap once, then keep
				if (!(btns[BTN_UP] && btns[BTN_DOWN])) begin
					vert_hold = 1'b0;
					pad_up    = btns[BTN_UP];
					pad_dn    = btns[BTN_DOWN];
				end else if (!vert_hold) begin
					vert_hold = 1'b1;
					{pad_up, pad_dn} = {pad_dn, pad_up};
				end
				if (!(btns[BTN_LEFT] && btns[BTN_RIGHT])) begin
					horiz_hold = 1'b0;
					pad_lt     = btns[BTN_LEFT];
					pad_rt     = btns[BTN_RIGHT];
				end else if (!horiz_hold) begin
					horiz_hold = 1'b1;
					{pad_lt, pad_rt} = {pad_rt, pad_lt};
				end
			end
		end
	endtask

	// acceptance flag, read by the sender at the falling edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			req_fire <= 1'b0;
		else
			req_fire <= req_if.valid && req_if.ready;
	end

	// predict accepted commands and check returned bits
	always @(posedge clk) begin : bit_checker
		logic produces;
		logic bit_val;
		logic exp_bit;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				pad_shift_predict(cmd_t'(req_if.command), req_if.latch_level,
					req_if.buttons, produces, bit_val);
				if (produces) begin
					reads_seen++;
					if (typed_flags.size() != 0 && typed_flags.pop_front())
						pending_serial_bits.push_back(typed_answers.pop_front());
					else
						pending_serial_bits.push_back(bit_val);
				end else begin
					latches_seen++;
					if (typed_flags.size() != 0)
						void'(typed_flags.pop_front());
				end
			end
			if (rsp_if.valid && rsp_if.ready) begin
				if (pending_serial_bits.size() == 0) begin
					bit_errors++;
					$display("%0t: unexpected serial_bit, expected none got %0b",
						$time, rsp_if.serial_bit);
				end else begin
					exp_bit = pending_serial_bits.pop_front();
					if (rsp_if.serial_bit !== exp_bit) begin
						bit_errors++;
						$display("%0t: serial_bit mismatch, expected %0b got %0b",
							$time, exp_bit, rsp_if.serial_bit);
					end
				end
			end
		end
	end

	// host stalls in random bursts, starting none in the quiet phase
	initial begin : host_ready
		int stall;
		stall = 0;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				rsp_if.ready <= 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 12) - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// drive one item from a falling edge until it is taken
	task automatic send_item(input cmd_t cmd, input logic lvl, input logic [BTN_W-1:0] btns);
		int gap;
		if (!quiet_phase && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 12);
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.command     <= cmd;
		req_if.latch_level <= lvl;
		req_if.buttons     <= btns;
		do @(negedge clk); while (!req_fire);
		items_sent++;
		if (items_sent >= DIR_COUNT + RAND_ITEMS - QUIET_ITEMS)
			quiet_phase = 1'b1;
	endtask

	// hold off until every owed bit has come back
	task automatic drain_pad();
		req_if.valid <= 1'b0;
		do @(negedge clk); while (pending_serial_bits.size() != 0);
	endtask

	// live buttons, often with opposing directions held together
	function automatic logic [BTN_W-1:0] pad_buttons();
		logic [BTN_W-1:0] b;
		b = BTN_W'($urandom_range(0, (1 << BTN_W) - 1));
		if ($urandom_range(0, 1)) begin
			b[BTN_UP]   = 1'b1;
			b[BTN_DOWN] = 1'b1;
		end
		if ($urandom_range(0, 1)) begin
			b[BTN_LEFT]  = 1'b1;
			b[BTN_RIGHT] = 1'b1;
		end
		return b;
	endfunction

	// stimulus
	initial begin : host_side
		int n;
		int k;
		pad_latched = 1'b0;
		pad_pos     = '0;
		pad_snap    = '0;
		pad_up      = 1'b0;
		pad_dn      = 1'b0;
		pad_lt      = 1'b0;
		pad_rt      = 1'b0;
		vert_hold   = 1'b0;
		horiz_hold  = 1'b0;
		bit_errors   = 0;
		items_sent   = 0;
		reads_seen   = 0;
		latches_seen = 0;
		frames_sent  = 0;
		quiet_phase  = 1'b0;
		req_if.valid       = 1'b0;
		req_if.command     = CMD_LATCH;
		req_if.latch_level = 1'b0;
		req_if.buttons     = '0;
		@(posedge arst_n);
		@(negedge clk);

		// opening command list
		for (int i = 0; i < DIR_COUNT; i++) begin
			typed_flags.push_back(DIR_ROWS[i].typed);
			if (DIR_ROWS[i].typed)
				typed_answers.push_back(DIR_ROWS[i].exp_bit);
			send_item(DIR_ROWS[i].cmd, DIR_ROWS[i].lvl, DIR_ROWS[i].btns);
		end
		drain_pad();

		// random frames with some noise in between
		while (items_sent < DIR_COUNT + RAND_ITEMS) begin
			if ($urandom_range(0, 9) < 7) begin
				frames_sent++;
				send_item(CMD_LATCH, 1'b1, pad_buttons());
				n = $urandom_range(0, 2);
				for (k = 0; k < n; k++)
					send_item(CMD_READ, 1'b0, pad_buttons());
				send_item(CMD_LATCH, 1'b0, pad_buttons());
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
					: $urandom_range(16, 20);
				for (k = 0; k < n; k++)
					send_item(CMD_READ, 1'($urandom_range(0, 1)), pad_buttons());
			end else begin
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++)
					send_item(cmd_t'(1'($urandom_range(0, 1))), 1'($urandom_range(0, 1)),
						BTN_W'($urandom_range(0, (1 << BTN_W) - 1)));
			end
			if (!quiet_phase && $urandom_range(0, 19) == 0)
				drain_pad();
		end

		// wind down and report
		drain_pad();
		repeat (8) @(negedge clk);
		if (pending_serial_bits.size() != 0) begin
			bit_errors++;
			$display("%0t: serial_bit missing, expected %0d more got none",
				$time, pending_serial_bits.size());
		end
		$display("covered %0d latch writes and %0d reads over %0d random frames",
			latches_seen, reads_seen, frames_sent);
		$display("including latched reads, both hold rules and saturated frames");
		if (bit_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#5_000_000;
		$display("timeout with %0d bits still owed", pending_serial_bits.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/gss_pkg.sv
sv/gss_if.sv
sv/gss_cell.sv
sv/gss_axis.sv
sv/gamepad_serial_shift_out.sv
sv/gss_checker.sv
verif/tb_top.sv
